// ===== rtl/dtc_pkg.sv =====
// Shared types, constants and command structure of the decimating tone correlator.
`default_nettype none

package dtc_pkg;

  // Sizes of the tap store, the delay line and the sample words.
  localparam int MAX_TAPS    = 64;
  localparam int IDX_W       = $clog2(MAX_TAPS);
  localparam int CNT_W       = $clog2(MAX_TAPS + 1);
  localparam int SAMPLE_BITS = 16;

  // Item field and configuration port widths.
  localparam int MODE_W    = 2;
  localparam int TAP_IDX_W = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  // Datapath widths: products, correlation sums, magnitudes and square roots.
  localparam int PROD_W   = 2 * SAMPLE_BITS;
  localparam int ACC_W    = PROD_W + IDX_W;
  localparam int MAG_W    = ACC_W + 1;
  localparam int LO_W     = MAG_W / 2;
  localparam int HI_W     = MAG_W - LO_W;
  localparam int ROOT_W   = MAG_W + 1;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int SCORE_W  = ROOT_W + 1;
  localparam int STEP_W   = $clog2(ROOT_W);
  localparam int DRAIN_RD = 2;

  // Item modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_TAP    = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAPS = 2'd0,
    CFG_DEC  = 2'd1
  } cfg_idx_e;

  // Partial product selection of the squarer.
  typedef enum logic [1:0] {
    PART_HH = 2'd0,
    PART_HL = 2'd1,
    PART_LL = 2'd2
  } sq_part_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             line_we;
    logic [IDX_W-1:0] line_waddr;
    logic             line_clr;
    logic             tap_we;
    logic [IDX_W-1:0] tap_waddr;
    logic             rd_en;
    logic [IDX_W-1:0] line_raddr;
    logic [IDX_W-1:0] tap_raddr;
    logic             acc_clr;
    logic             ops_load;
    logic             ops_neg;
    logic             sq_clr;
    logic             sq_en;
    logic             sq_im;
    sq_part_e         sq_part;
    logic             rt_init;
    logic             rt_en;
    logic             mp_save;
    logic             out_load;
  } dtc_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/dtc_in_if.sv =====
// Input channel interface: valid, ready and the item fields.
`default_nettype none

interface dtc_in_if;
  import dtc_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [MODE_W-1:0]             mode;
  logic [TAP_IDX_W-1:0]          tap_index;
  logic signed [SAMPLE_BITS-1:0] tap_real;
  logic signed [SAMPLE_BITS-1:0] tap_imag;
  logic signed [SAMPLE_BITS-1:0] sample_real;
  logic signed [SAMPLE_BITS-1:0] sample_imag;

  modport source (output valid, mode, tap_index, tap_real, tap_imag, sample_real,
                  sample_imag, input ready);
  modport sink (input valid, mode, tap_index, tap_real, tap_imag, sample_real,
                sample_imag, output ready);
endinterface

`default_nettype wire

// ===== rtl/dtc_out_if.sv =====
// Result channel interface: valid, ready and the score.
`default_nettype none

interface dtc_out_if;
  import dtc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;

  modport source (output valid, score, input ready);
  modport sink (input valid, score, output ready);
endinterface

`default_nettype wire

// ===== rtl/dtc_datapath.sv =====
// Datapath: delay line and tap memories, correlator, squarer and square root unit.
`default_nettype none

module dtc_datapath (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire dtc_pkg::dtc_cmd_t                      cmd_i,
  input  wire logic signed [dtc_pkg::SAMPLE_BITS-1:0] tap_real_i,
  input  wire logic signed [dtc_pkg::SAMPLE_BITS-1:0] tap_imag_i,
  input  wire logic signed [dtc_pkg::SAMPLE_BITS-1:0] sample_real_i,
  input  wire logic signed [dtc_pkg::SAMPLE_BITS-1:0] sample_imag_i,
  output logic signed [dtc_pkg::SCORE_W-1:0]          score_o
);
  import dtc_pkg::*;

  // Memories hold {real, imaginary}.
  logic [2*SAMPLE_BITS-1:0] line_mem [MAX_TAPS];
  logic [2*SAMPLE_BITS-1:0] tap_mem  [MAX_TAPS];
  logic [MAX_TAPS-1:0]      line_vld_q;

  logic [2*SAMPLE_BITS-1:0] line_rd_q, tap_rd_q;
  logic                     lv_q, rd_v_q;

  logic signed [SAMPLE_BITS-1:0] lr, li, tr, ti;
  logic signed [PROD_W-1:0]      p_rr_q, p_ii_q, p_ir_q, p_ri_q;
  logic                          pv_q;
  logic signed [ACC_W-1:0]       acc_rr_q, acc_ii_q, acc_ir_q, acc_ri_q;

  logic signed [MAG_W-1:0] x_re, x_im;
  logic [MAG_W-1:0]        a_re_q, a_im_q, op;
  logic [HI_W-1:0]         op_hi, op_lo;
  logic [2*HI_W-1:0]       mprod;
  logic [RAD_W-1:0]        pp_d, pp_q, n_q;
  logic                    ppv_q;

  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W+1:0] rem_q, rem_sh, trial;
  logic [ROOT_W-1:0] root_q, mp_q;
  logic [SCORE_W-1:0] score_q;

  // Memory writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.line_we) begin
      line_mem[cmd_i.line_waddr] <= {sample_real_i, sample_imag_i};
    end
    if (cmd_i.tap_we) begin
      tap_mem[cmd_i.tap_waddr] <= {tap_real_i, tap_imag_i};
    end
    line_rd_q <= line_mem[cmd_i.line_raddr];
    tap_rd_q  <= tap_mem[cmd_i.tap_raddr];
  end

  // Valid bits of the delay line; an entry never written since a clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_vld_q <= '0;
      lv_q       <= 1'b0;
      rd_v_q     <= 1'b0;
      pv_q       <= 1'b0;
      ppv_q      <= 1'b0;
    end else begin
      if (cmd_i.line_clr) begin
        line_vld_q <= '0;
      end else if (cmd_i.line_we) begin
        line_vld_q[cmd_i.line_waddr] <= 1'b1;
      end
      lv_q   <= line_vld_q[cmd_i.line_raddr];
      rd_v_q <= cmd_i.rd_en;
      pv_q   <= rd_v_q;
      ppv_q  <= cmd_i.sq_en;
    end
  end

  // Complex products of one line entry with one tap.
  always_comb begin
    lr = lv_q ? line_rd_q[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;
    li = lv_q ? line_rd_q[SAMPLE_BITS-1:0] : '0;
    tr = tap_rd_q[2*SAMPLE_BITS-1:SAMPLE_BITS];
    ti = tap_rd_q[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk_i) begin
    p_rr_q <= lr * tr;
    p_ii_q <= li * ti;
    p_ir_q <= li * tr;
    p_ri_q <= lr * ti;
  end

  // Correlation accumulators.
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      acc_rr_q <= '0;
      acc_ii_q <= '0;
      acc_ir_q <= '0;
      acc_ri_q <= '0;
    end else if (pv_q) begin
      acc_rr_q <= acc_rr_q + ACC_W'(p_rr_q);
      acc_ii_q <= acc_ii_q + ACC_W'(p_ii_q);
      acc_ir_q <= acc_ir_q + ACC_W'(p_ir_q);
      acc_ri_q <= acc_ri_q + ACC_W'(p_ri_q);
    end
  end

  // Real and imaginary parts against the taps or against their conjugates.
  always_comb begin
    if (cmd_i.ops_neg) begin
      x_re = MAG_W'(acc_rr_q) + MAG_W'(acc_ii_q);
      x_im = MAG_W'(acc_ir_q) - MAG_W'(acc_ri_q);
    end else begin
      x_re = MAG_W'(acc_rr_q) - MAG_W'(acc_ii_q);
      x_im = MAG_W'(acc_ir_q) + MAG_W'(acc_ri_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ops_load) begin
      a_re_q <= x_re[MAG_W-1] ? MAG_W'(-x_re) : MAG_W'(x_re);
      a_im_q <= x_im[MAG_W-1] ? MAG_W'(-x_im) : MAG_W'(x_im);
    end
  end

  // Squarer: each square is built from three half-width partial products.
  always_comb begin
    op    = cmd_i.sq_im ? a_im_q : a_re_q;
    op_hi = op[MAG_W-1:LO_W];
    op_lo = HI_W'(op[LO_W-1:0]);
    case (cmd_i.sq_part)
      PART_HH: begin
        mprod = op_hi * op_hi;
        pp_d  = RAD_W'(mprod) << (2 * LO_W);
      end
      PART_HL: begin
        mprod = op_hi * op_lo;
        pp_d  = RAD_W'(mprod) << (LO_W + 1);
      end
      default: begin
        mprod = op_lo * op_lo;
        pp_d  = RAD_W'(mprod);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    pp_q <= pp_d;
    if (cmd_i.sq_clr) begin
      n_q <= '0;
    end else if (ppv_q) begin
      n_q <= n_q + pp_q;
    end
  end

  // Square root, one result bit per cycle.
  always_comb begin
    rem_sh = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
    trial  = {root_q, 2'b01};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rt_init) begin
      rad_q  <= n_q;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.rt_en) begin
      rad_q <= rad_q << 2;
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.mp_save) begin
      mp_q <= root_q;
    end
    if (cmd_i.out_load) begin
      score_q <= {1'b0, mp_q} - {1'b0, root_q};
    end
  end

  assign score_o = score_q;

endmodule

`default_nettype wire

// ===== rtl/dtc_controller.sv =====
// Controller: configuration registers, handshakes, phase and line pointer, sequencing.
`default_nettype none

module dtc_controller (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dtc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [dtc_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  input  wire logic [dtc_pkg::MODE_W-1:0]        in_mode_i,
  input  wire logic [dtc_pkg::TAP_IDX_W-1:0]     in_tap_index_i,
  output logic                                   in_ready_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output dtc_pkg::dtc_cmd_t                      cmd_o
);
  import dtc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DRAIN, S_OPS, S_SQ, S_SQW, S_RINIT, S_ROOT, S_MAG, S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   taps_q, taps_d, dec_q, dec_d;
  logic [IDX_W-1:0]   phase_q, phase_d, base_q, base_d;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;
  logic               neg_q, neg_d, sq_im_q, sq_im_d;
  sq_part_e           part_q, part_d;
  logic               out_valid_q, out_valid_d;

  logic [CNT_W-1:0] t_eff, d_raw, d_eff, phase_eff, phase_inc, wpos, tr_idx;
  logic             accept;

  // Ring position of a logical line index.
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] s);
    logic [CNT_W:0] r;
    r = (s >= (CNT_W+1)'(MAX_TAPS)) ? s - (CNT_W+1)'(MAX_TAPS) : s;
    return r[IDX_W-1:0];
  endfunction

  // Effective sizes and write position of the next sample.
  always_comb begin
    t_eff     = (taps_q > CFG_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(taps_q);
    d_raw     = (dec_q == '0) ? CNT_W'(1) : CNT_W'(dec_q);
    d_eff     = (d_raw > t_eff) ? t_eff : d_raw;
    phase_eff = (CNT_W'(phase_q) >= d_eff) ? '0 : CNT_W'(phase_q);
    phase_inc = phase_eff + CNT_W'(1);
    wpos      = t_eff - d_eff + phase_eff;
    tr_idx    = t_eff - CNT_W'(1) - n_q;
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    taps_d      = taps_q;
    dec_d       = dec_q;
    phase_d     = phase_q;
    base_d      = base_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    sq_im_d     = sq_im_q;
    part_d      = part_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.ops_neg    = neg_q;
    cmd_o.sq_im      = sq_im_q;
    cmd_o.sq_part    = part_q;
    cmd_o.line_waddr = wrap_idx({1'b0, CNT_W'(base_q)} + {1'b0, wpos});
    cmd_o.tap_waddr  = IDX_W'(in_tap_index_i);
    cmd_o.line_raddr = wrap_idx({1'b0, CNT_W'(base_q)} + {1'b0, n_q});
    cmd_o.tap_raddr  = tr_idx[IDX_W-1:0];
    in_ready_o  = (state_q == S_IDLE);
    out_valid_o = out_valid_q;
    accept      = in_valid_i && in_ready_o;

    // Register writes clear the delay line and the phase.
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TAPS: begin
          taps_d         = cfg_data_i;
          cmd_o.line_clr = 1'b1;
          phase_d        = '0;
        end
        CFG_DEC: begin
          dec_d          = cfg_data_i;
          cmd_o.line_clr = 1'b1;
          phase_d        = '0;
        end
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_mode_i)
            MODE_TAP: begin
              cmd_o.tap_we = (32'(in_tap_index_i) < MAX_TAPS);
            end
            MODE_CLEAR: begin
              cmd_o.line_clr = 1'b1;
              phase_d        = '0;
            end
            MODE_SAMPLE: begin
              if (t_eff != '0) begin
                cmd_o.line_we = 1'b1;
                if (phase_inc == d_eff) begin
                  phase_d       = '0;
                  cmd_o.acc_clr = 1'b1;
                  n_d           = '0;
                  state_d       = S_READ;
                end else begin
                  phase_d = phase_inc[IDX_W-1:0];
                end
              end
            end
            default: ;
          endcase
        end
      end
      // Walk the line and the reversed taps, one pair a cycle.
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        n_d         = n_q + CNT_W'(1);
        if (n_q == t_eff - CNT_W'(1)) begin
          base_d  = wrap_idx({1'b0, CNT_W'(base_q)} + {1'b0, d_eff});
          cnt_d   = '0;
          neg_d   = 1'b0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cnt_d = cnt_q + STEP_W'(1);
        if (cnt_q == STEP_W'(DRAIN_RD - 1)) begin
          state_d = S_OPS;
        end
      end
      S_OPS: begin
        cmd_o.ops_load = 1'b1;
        cmd_o.sq_clr   = 1'b1;
        sq_im_d        = 1'b0;
        part_d         = PART_HH;
        state_d        = S_SQ;
      end
      // Six partial products: three for the real part, three for the imaginary part.
      S_SQ: begin
        cmd_o.sq_en = 1'b1;
        case (part_q)
          PART_HH: part_d = PART_HL;
          PART_HL: part_d = PART_LL;
          default: begin
            part_d = PART_HH;
            if (sq_im_q) begin
              state_d = S_SQW;
            end else begin
              sq_im_d = 1'b1;
            end
          end
        endcase
      end
      S_SQW: begin
        state_d = S_RINIT;
      end
      S_RINIT: begin
        cmd_o.rt_init = 1'b1;
        cnt_d         = '0;
        state_d       = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.rt_en = 1'b1;
        cnt_d       = cnt_q + STEP_W'(1);
        if (cnt_q == STEP_W'(ROOT_W - 1)) begin
          state_d = S_MAG;
        end
      end
      S_MAG: begin
        if (neg_q) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mp_save = 1'b1;
          neg_d         = 1'b1;
          state_d       = S_OPS;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      taps_q      <= '0;
      dec_q       <= CFG_W'(1);
      phase_q     <= '0;
      base_q      <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      sq_im_q     <= 1'b0;
      part_q      <= PART_HH;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      taps_q      <= taps_d;
      dec_q       <= dec_d;
      phase_q     <= phase_d;
      base_q      <= base_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      sq_im_q     <= sq_im_d;
      part_q      <= part_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/decimating_tone_correlator.sv =====
// Top level of the decimating tone correlator.
//
// Input channel in_i (valid/ready) carries one item per transaction: a sample, a
// tap write (stored at its index) or a clear of the delay line and phase.
// Result channel out_o (valid/ready) carries one signed score per transaction.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 = taps in
// use, 1 = decimation); a write clears the line and the phase.
// Tap writes, clears and samples that do not finish a decimation period are
// taken without holding off input. A sample that completes a period starts a
// correlation: one tap pair a cycle through the line and tap memory ports, a
// drain of the read and product registers, then for each of the two magnitudes
// six squarer steps and a bit-serial square root. Input is held off during that
// computation.
// The result sits in an output register, so new items are taken while it
// waits; a second result waits in the controller until the first is taken.
// Reset clears the registers (no taps, decimation one), the phase and the line
// valid bits; the tap store holds nothing defined until written.
`default_nettype none

module decimating_tone_correlator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dtc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dtc_pkg::CFG_W-1:0]     cfg_data_i,
  dtc_in_if.sink                             in_i,
  dtc_out_if.source                          out_o
);
  import dtc_pkg::*;

  dtc_cmd_t cmd;

  // Sequencing and handshakes.
  dtc_controller u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_i.valid),
    .in_mode_i      (in_i.mode),
    .in_tap_index_i (in_i.tap_index),
    .in_ready_o     (in_i.ready),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .cmd_o          (cmd)
  );

  // Memories and arithmetic.
  dtc_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .tap_real_i    (in_i.tap_real),
    .tap_imag_i    (in_i.tap_imag),
    .sample_real_i (in_i.sample_real),
    .sample_imag_i (in_i.sample_imag),
    .score_o       (out_o.score)
  );

endmodule

`default_nettype wire

// ===== rtl/dtc_checker.sv =====
// Port-level assertions for the decimating tone correlator, bound to the top level.
`default_nettype none

module dtc_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_i,
  input wire logic [dtc_pkg::MODE_W-1:0]    in_mode_i,
  input wire logic                          out_valid_i,
  input wire logic                          out_ready_i,
  input wire logic [dtc_pkg::SCORE_W-1:0]   out_score_i
);
  import dtc_pkg::*;

  // A waiting result is held with its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_score_i))
    else $error("result dropped or changed while stalled");

  // A new result only appears at the end of a computation, when input is held off.
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a computation");

  // Tap writes and clears do not hold off the input.
  a_fast_items: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == MODE_TAP || in_mode_i == MODE_CLEAR)
    |=> in_ready_i)
    else $error("tap write or clear stalled the input");

  // Input is held off only after an accepted sample.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i) && $past(in_mode_i) == MODE_SAMPLE)
    else $error("input held off without a sample transaction");

endmodule

bind decimating_tone_correlator dtc_checker u_dtc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_score_i (out_o.score)
);

`default_nettype wire
